// ===== rtl/core/cfvp_pkg.sv =====
package cfvp_pkg;

  localparam int unsigned FrameLength = 128;
  localparam int unsigned PosW        = $clog2(FrameLength);
  localparam int unsigned WalkW       = 10;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [7:0] SeqResetHost = 8'h81;
  localparam logic [7:0] SeqResetDev  = 8'h80;
  localparam logic [7:0] SeqStart     = 8'h01;
  localparam logic [7:0] NullId       = 8'h00;
  localparam logic [7:0] HeaderReset  = 8'h53;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_BAD_SEQ = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER = 3'd0,
    REG_MASK0  = 3'd1,
    REG_MASK1  = 3'd2,
    REG_MASK2  = 3'd3,
    REG_MASK3  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  frame_status;
    logic [7:0]  sequence_number;
    logic [7:0]  cmd_id;
    logic [7:0]  cmd_len;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_bytes;
    logic        last_of_command;
    logic        last_of_frame;
  } out_t;

  // One finished frame handed from front to back
  typedef struct packed {
    logic       bank;
    status_e    status;
    logic [7:0] seq;
    logic [7:0] ncmd;
  } job_t;

  // Frame store write port driven by the front
  typedef struct packed {
    logic            en;
    logic [PosW:0]   addr;
    logic [7:0]      data;
  } mem_wr_t;

endpackage

// ===== rtl/core/cfvp_front.sv =====
module cfvp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfvp_pkg::in_t    in_data_i,
  input  logic [7:0]       header_id_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cfvp_pkg::job_t   job_o,
  output cfvp_pkg::mem_wr_t wr_o
);
  import cfvp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, p;
  logic [7:0]      sum_q, sum_d, s, b;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      hdr_q, seqb_q, ncmd_q;
  logic            bank_q;
  logic            acc, last;
  status_e         st;

  assign in_ready_o = !q_full_i;
  assign acc  = in_valid_i && in_ready_o;
  assign b    = in_data_i.rx_byte;
  assign p    = in_data_i.frame_start ? '0 : pos_q;
  assign s    = in_data_i.frame_start ? '0 : sum_q;
  assign last = (p == PosW'(FrameLength - 1));

  // Frame checks and sequence rule at the last byte
  always_comb begin
    st    = ST_OK;
    seq_d = seq_q;
    if (hdr_q != header_id_i) begin
      st = ST_BAD_HDR;
    end else if (b != s) begin
      st = ST_BAD_SUM;
    end else if (seqb_q == SeqResetHost && seq_q == SeqResetDev) begin
      seq_d = SeqStart;
    end else if (seqb_q == SeqResetHost) begin
      seq_d = SeqResetDev;
    end else if (seqb_q[7] || seqb_q == seq_q) begin
      st = ST_BAD_SEQ;
    end else begin
      seq_d = seqb_q;
    end
  end

  assign pos_d = last ? '0 : p + PosW'(1);
  assign sum_d = last ? '0 : s + b;

  assign wr_o.en   = acc;
  assign wr_o.addr = {bank_q, p};
  assign wr_o.data = b;

  assign push_o      = acc && last;
  assign job_o.bank   = bank_q;
  assign job_o.status = st;
  assign job_o.seq    = seq_d;
  assign job_o.ncmd   = ncmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      seq_q  <= '0;
      bank_q <= 1'b0;
    end else if (acc) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (last) begin
        seq_q  <= seq_d;
        bank_q <= !bank_q;
      end
    end
  end

  // Header, sequence and count bytes kept aside
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (p == PosW'(0)) hdr_q  <= b;
      if (p == PosW'(1)) seqb_q <= b;
      if (p == PosW'(2)) ncmd_q <= b;
    end
  end

endmodule

// ===== rtl/core/cfvp_queue.sv =====
module cfvp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfvp_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output cfvp_pkg::job_t job_o,
  input  logic           pop_i
);
  import cfvp_pkg::*;

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= job_i;
  end

endmodule

// ===== rtl/core/cfvp_back.sv =====
module cfvp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfvp_pkg::mem_wr_t wr_i,
  input  logic              q_valid_i,
  input  cfvp_pkg::job_t    q_job_i,
  output logic              pop_o,
  input  logic [255:0]      mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfvp_pkg::out_t    out_data_o
);
  import cfvp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CMD   = 8'b0000_0010,
    S_ID    = 8'b0000_0100,
    S_LEN   = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_DATA  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_e;

  localparam logic [WalkW-1:0] WalkEnd = WalkW'(FrameLength - 2);

  // Double-banked frame store
  logic [7:0]  mem_q [2*FrameLength];
  logic [7:0]  rdata_q;
  logic [WalkW-1:0] raddr;

  state_e state_q, state_d;
  logic [WalkW-1:0] a_q, a_d, ptr_q, ptr_d;
  logic [7:0]  c_q, c_d, id_q, id_d, len_q, len_d, cs_q, cs_d, off_q, off_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] data_q, data_d;
  logic [WalkW-1:0] cs_pos;
  out_t  out_q, pend_q, res, fin;
  logic  out_v_q, pend_v_q;
  logic  out_free, can_emit, emit, flush;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    rdata_q <= mem_q[{q_job_i.bank, raddr[PosW-1:0]}];
  end

  assign out_free = !out_v_q || out_ready_i;
  assign can_emit = !pend_v_q || out_free;
  assign cs_pos   = a_q + WalkW'(len_q) + WalkW'(2);

  // Command walk
  always_comb begin
    state_d = state_q;
    a_d = a_q; ptr_d = ptr_q; c_d = c_q; id_d = id_q; len_d = len_q;
    cs_d = cs_q; off_d = off_q; cnt_d = cnt_q; data_d = data_q;
    raddr = '0;
    emit  = 1'b0;
    flush = 1'b0;
    pop_o = 1'b0;
    res   = '0;
    res.sequence_number = q_job_i.seq;
    unique case (state_q)
      S_IDLE: begin
        res.frame_status = q_job_i.status;
        if (q_valid_i && can_emit) begin
          emit = 1'b1;
          a_d  = WalkW'(3);
          c_d  = '0;
          state_d = (q_job_i.status == ST_OK) ? S_CMD : S_FLUSH;
        end
      end
      S_CMD: begin
        raddr = a_q;
        if (c_q == q_job_i.ncmd || a_q + WalkW'(1) > WalkEnd) state_d = S_FLUSH;
        else state_d = S_ID;
      end
      S_ID: begin
        id_d  = rdata_q;
        raddr = a_q + WalkW'(1);
        state_d = S_LEN;
      end
      S_LEN: begin
        len_d = rdata_q;
        if (a_q + WalkW'(rdata_q) + WalkW'(2) > WalkEnd) begin
          state_d = S_FLUSH;
        end else begin
          cs_d  = id_q + rdata_q;
          ptr_d = a_q + WalkW'(2);
          raddr = a_q + WalkW'(2);
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (ptr_q == cs_pos) begin
          if (rdata_q == cs_q && id_q != NullId && mask_i[id_q]) begin
            off_d = '0; cnt_d = '0; data_d = '0;
            raddr = a_q + WalkW'(2);
            state_d = (len_q == 8'd0) ? S_EMIT : S_DATA;
          end else begin
            a_d = a_q + WalkW'(len_q) + WalkW'(3);
            c_d = c_q + 8'd1;
            state_d = S_CMD;
          end
        end else begin
          cs_d  = cs_q + rdata_q;
          ptr_d = ptr_q + WalkW'(1);
          raddr = ptr_q + WalkW'(1);
        end
      end
      S_DATA: begin
        data_d[8*cnt_q[2:0] +: 8] = rdata_q;
        cnt_d = cnt_q + 4'd1;
        off_d = off_q + 8'd1;
        raddr = a_q + WalkW'(2) + WalkW'(off_q) + WalkW'(1);
        if (cnt_q == 4'd7 || off_q + 8'd1 == len_q) state_d = S_EMIT;
      end
      S_EMIT: begin
        res.kind            = 1'b1;
        res.cmd_id          = id_q;
        res.cmd_len         = len_q;
        res.chunk_data      = data_q;
        res.chunk_bytes     = cnt_q;
        res.last_of_command = (off_q == len_q);
        raddr = a_q + WalkW'(2) + WalkW'(off_q);
        if (can_emit) begin
          emit = 1'b1;
          data_d = '0;
          cnt_d  = '0;
          if (off_q != len_q) begin
            state_d = S_DATA;
          end else begin
            a_d = a_q + WalkW'(len_q) + WalkW'(3);
            c_d = c_q + 8'd1;
            state_d = S_CMD;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          flush = 1'b1;
          pop_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pending result marked as the end of its frame
  always_comb begin
    fin = pend_q;
    fin.last_of_frame = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        pend_v_q <= 1'b1;
        if (pend_v_q)         out_v_q <= 1'b1;
        else if (out_ready_i) out_v_q <= 1'b0;
      end else if (flush) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Pending result waits until we know whether it ends the frame
  always_ff @(posedge clk_i) begin
    a_q <= a_d; ptr_q <= ptr_d; c_q <= c_d; id_q <= id_d; len_q <= len_d;
    cs_q <= cs_d; off_q <= off_d; cnt_q <= cnt_d; data_q <= data_d;
    if (emit) begin
      pend_q <= res;
      if (pend_v_q) out_q <= pend_q;
    end else if (flush) begin
      out_q <= fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/command_frame_validator_parser.sv =====
// Channel  | Direction | Handshake              | Beat
// in       | input     | in_valid_i/in_ready_o  | in_data_i (rx_byte, frame_start)
// out      | output    | out_valid_o/out_ready_i| out_data_o (one result)
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Bytes are taken one per cycle while the two-entry frame queue has room;
// the frame store has two banks, so one frame loads while the previous one
// is walked. A command is checked by reading its id, length, data and sum;
// an emitted command is then read out in chunks of up to eight bytes. A long
// walk can fill the queue, and then the input stalls. Reset clears all
// control state; the frame store needs no clearing. cfg is always ready.
module command_frame_validator_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cfvp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cfvp_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfvp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);
  import cfvp_pkg::*;

  logic [7:0]   header_q;
  logic [255:0] mask_q;
  logic         q_full, q_valid, push, pop;
  job_t         job_in, job_head;
  mem_wr_t      wr;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      mask_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HEADER: header_q        <= cfg_data_i[7:0];
        REG_MASK0:  mask_q[63:0]    <= cfg_data_i;
        REG_MASK1:  mask_q[127:64]  <= cfg_data_i;
        REG_MASK2:  mask_q[191:128] <= cfg_data_i;
        REG_MASK3:  mask_q[255:192] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfvp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .header_id_i(header_q), .q_full_i(q_full), .push_o(push),
    .job_o(job_in), .wr_o(wr)
  );

  cfvp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(q_full),
    .valid_o(q_valid), .job_o(job_head), .pop_i(pop)
  );

  cfvp_back u_back (
    .clk_i, .rst_ni, .wr_i(wr), .q_valid_i(q_valid), .q_job_i(job_head),
    .pop_o(pop), .mask_i(mask_q), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ===== dv/tb_command_frame_validator_parser.sv =====
module tb_command_frame_validator_parser;
  import cfvp_pkg::*;

  localparam int unsigned FrameLen    = FrameLength;
  localparam int unsigned MaxResults  = 42;
  localparam int unsigned DrainCycles = 800;
  localparam int unsigned HoldCycles  = 700;
  localparam int unsigned StallLimit  = 6000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  command_frame_validator_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block's state and registers
  logic [7:0]  shadow_store [FrameLen];
  int          shadow_pos;
  logic [7:0]  shadow_sum;
  logic [7:0]  shadow_seq;
  logic [7:0]  shadow_header;
  logic [63:0] shadow_mask [4];

  out_t        expected_beats [$];
  int          errors;
  bit          quiet;
  int          hold_left;
  bit          hold_req;

  // frame under construction
  logic [7:0]  frame_buf [FrameLen];
  int          frame_wr;

  // Work out the beats one input byte causes
  task automatic predict_byte(input in_t b);
    out_t       r;
    out_t       frame_beats [$];
    status_e    st;
    logic [7:0] total, cs, id, pn;
    int         a, len, off, cnt, n;
    logic [63:0] data;
    if (b.frame_start) begin
      shadow_pos = 0;
      shadow_sum = '0;
    end
    shadow_store[shadow_pos] = b.rx_byte;
    if (shadow_pos < FrameLen - 1) begin
      shadow_sum += b.rx_byte;
      shadow_pos++;
      return;
    end
    shadow_pos = 0;
    total = shadow_sum;
    shadow_sum = '0;
    // header, frame sum, then the sequence rule
    st = ST_OK;
    pn = shadow_store[1];
    if (shadow_store[0] != shadow_header) st = ST_BAD_HDR;
    else if (shadow_store[FrameLen-1] != total) st = ST_BAD_SUM;
    else if (pn == SeqResetHost && shadow_seq == SeqResetDev) shadow_seq = SeqStart;
    else if (pn == SeqResetHost) shadow_seq = SeqResetDev;
    else if (pn[7] || pn == shadow_seq) st = ST_BAD_SEQ;
    else shadow_seq = pn;
    r = '0;
    r.frame_status = st;
    r.sequence_number = shadow_seq;
    frame_beats.push_back(r);
    n = 1;
    // command walk
    if (st == ST_OK) begin
      a = 3;
      for (int c = 0; c < shadow_store[2]; c++) begin
        if (a + 1 > FrameLen - 2) break;
        len = shadow_store[a+1];
        if (a + len + 2 > FrameLen - 2) break;
        cs = '0;
        for (int i = a; i < a + len + 2; i++) cs += shadow_store[i];
        id = shadow_store[a];
        if (cs == shadow_store[a+len+2] && id != NullId && shadow_mask[id[7:6]][id[5:0]]) begin
          off = 0;
          do begin
            cnt = (len - off > 8) ? 8 : len - off;
            data = '0;
            for (int i = 0; i < cnt; i++) data[8*i +: 8] = shadow_store[a+2+off+i];
            if (n >= MaxResults) break;
            r = '0;
            r.kind = 1'b1;
            r.sequence_number = shadow_seq;
            r.cmd_id = id;
            r.cmd_len = len[7:0];
            r.chunk_data = data;
            r.chunk_bytes = cnt[3:0];
            r.last_of_command = (off + cnt >= len);
            frame_beats.push_back(r);
            n++;
            off += cnt;
          end while (off < len);
        end
        a += len + 3;
      end
    end
    frame_beats[$].last_of_frame = 1'b1;
    foreach (frame_beats[i]) expected_beats.push_back(frame_beats[i]);
  endtask

  // Compare one output beat with the oldest expected beat
  task automatic check_beat(input out_t act);
    out_t e;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat %h", $time, act);
      errors++;
      return;
    end
    e = expected_beats.pop_front();
    if (act.kind != e.kind)
      $display("%0t: kind exp %h got %h", $time, e.kind, act.kind);
    if (act.frame_status != e.frame_status)
      $display("%0t: frame_status exp %h got %h", $time, e.frame_status, act.frame_status);
    if (act.sequence_number != e.sequence_number)
      $display("%0t: sequence_number exp %h got %h", $time, e.sequence_number,
               act.sequence_number);
    if (act.cmd_id != e.cmd_id)
      $display("%0t: cmd_id exp %h got %h", $time, e.cmd_id, act.cmd_id);
    if (act.cmd_len != e.cmd_len)
      $display("%0t: cmd_len exp %h got %h", $time, e.cmd_len, act.cmd_len);
    if (act.chunk_data != e.chunk_data)
      $display("%0t: chunk_data exp %h got %h", $time, e.chunk_data, act.chunk_data);
    if (act.chunk_bytes != e.chunk_bytes)
      $display("%0t: chunk_bytes exp %h got %h", $time, e.chunk_bytes, act.chunk_bytes);
    if (act.last_of_command != e.last_of_command)
      $display("%0t: last_of_command exp %h got %h", $time, e.last_of_command,
               act.last_of_command);
    if (act.last_of_frame != e.last_of_frame)
      $display("%0t: last_of_frame exp %h got %h", $time, e.last_of_frame, act.last_of_frame);
    if (act !== e) errors++;
  endtask

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) check_beat(out_data);
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HoldCycles;
      hold_req  <= 1'b0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // watchdog on cycles without any accepted beat
  int stall_cycles;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("[command_frame_validator_parser] ERROR");
      $finish;
    end
  end

  // Send one byte beat, at random with in_valid dropped in front of it when not quiet
  task automatic send_byte(input logic [7:0] val, input logic start);
    in_t b;
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    b.rx_byte = val;
    b.frame_start = start;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic start);
    for (int i = 0; i < FrameLen; i++) send_byte(frame_buf[i], start && i == 0);
  endtask

  // Wait until nothing is pending, then write a register
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_HEADER: shadow_header = val[7:0];
      REG_MASK0:  shadow_mask[0] = val;
      REG_MASK1:  shadow_mask[1] = val;
      REG_MASK2:  shadow_mask[2] = val;
      REG_MASK3:  shadow_mask[3] = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bit cmd_fits(input int len);
    return frame_wr + len + 2 <= FrameLen - 2;
  endfunction

  // Append a command with its sum, optionally corrupted
  function automatic void add_cmd(input logic [7:0] id, input int len, input bit good);
    logic [7:0] cs;
    frame_buf[frame_wr] = id;
    frame_buf[frame_wr+1] = len[7:0];
    cs = id + len[7:0];
    for (int i = 0; i < len; i++) begin
      frame_buf[frame_wr+2+i] = $urandom_range(255);
      cs += frame_buf[frame_wr+2+i];
    end
    frame_buf[frame_wr+len+2] = good ? cs : cs ^ (8'h01 << $urandom_range(7));
    frame_wr += len + 3;
  endfunction

  // Fill the tail, set the header bytes and the frame sum
  function automatic void close_frame(input logic [7:0] hdr, input logic [7:0] seqb,
                                      input logic [7:0] ncmd, input bit good);
    logic [7:0] s;
    for (int i = frame_wr; i < FrameLen - 1; i++) frame_buf[i] = $urandom_range(255);
    frame_buf[0] = hdr;
    frame_buf[1] = seqb;
    frame_buf[2] = ncmd;
    s = '0;
    for (int i = 0; i < FrameLen - 1; i++) s += frame_buf[i];
    frame_buf[FrameLen-1] = good ? s : s ^ (8'h01 << $urandom_range(7));
  endfunction

  function automatic logic [7:0] next_seq();
    logic [7:0] s;
    s = {1'b0, shadow_seq[6:0] + 7'd1};
    return (s == 8'h00) ? 8'h01 : s;
  endfunction

  // Random frame with well-formed commands; bad_pct corrupts some of them
  function automatic void random_frame(input logic [7:0] seqb, input int bad_pct,
                                       input int max_len);
    int n, len;
    frame_wr = 3;
    n = 0;
    forever begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(max_len);
      if (!cmd_fits(len) || $urandom_range(15) == 0) break;
      add_cmd(($urandom_range(7) == 0) ? NullId : 8'($urandom_range(255)), len,
              $urandom_range(99) >= bad_pct);
      n++;
    end
    if ($urandom_range(9) == 0) n += $urandom_range(1, 5);
    close_frame(shadow_header, seqb, n[7:0], 1'b1);
  endfunction

  // Defaults after reset: frame accepted, masks empty so only status
  task automatic test_reset_defaults();
    quiet = 1'b1;
    frame_wr = 3;
    add_cmd(8'h05, 4, 1'b1);
    close_frame(HeaderReset, SeqResetHost, 8'd1, 1'b1);
    send_frame(1'b1);
    quiet = 1'b0;
  endtask

  // Extreme register values and each command case
  task automatic test_command_cases();
    write_reg(REG_HEADER, 64'h0);
    write_reg(REG_MASK0, '1);
    write_reg(REG_MASK1, '1);
    write_reg(REG_MASK2, '1);
    write_reg(REG_MASK3, '1);
    write_reg(RegUnused, 64'h0);
    frame_wr = 3;
    add_cmd(NullId, 3, 1'b1);
    add_cmd(8'h01, 0, 1'b1);
    add_cmd(8'h7F, 8, 1'b1);
    add_cmd(8'h80, 9, 1'b1);
    add_cmd(8'hFF, 17, 1'b1);
    add_cmd(8'h40, 5, 1'b0);
    add_cmd(8'hC1, 2, 1'b1);
    close_frame(8'h00, SeqResetHost, 8'd7, 1'b1);
    send_frame(1'b1);
    // maximum chunk count: many zero length commands
    frame_wr = 3;
    while (cmd_fits(0)) add_cmd(8'($urandom_range(1, 255)), 0, 1'b1);
    close_frame(8'h00, next_seq(), 8'd255, 1'b1);
    send_frame(1'b1);
    // command running past the end of the frame
    frame_wr = 3;
    add_cmd(8'h22, 60, 1'b1);
    frame_buf[frame_wr] = 8'h33;
    frame_buf[frame_wr+1] = 8'd120;
    frame_wr += 2;
    close_frame(8'h00, next_seq(), 8'd2, 1'b1);
    send_frame(1'b1);
  endtask

  // Header, sum and sequence failures, resync and wraparound
  task automatic test_frame_errors();
    write_reg(REG_HEADER, 64'hFF);
    write_reg(REG_MASK0, 64'h0);
    write_reg(REG_MASK2, 64'h0);
    random_frame(next_seq(), 0, 8);
    frame_buf[0] = 8'hFE;
    send_frame(1'b1);
    random_frame(next_seq(), 0, 8);
    frame_buf[FrameLen-1] ^= 8'h80;
    send_frame(1'b1);
    random_frame(8'h90, 0, 8);
    send_frame(1'b1);
    random_frame(shadow_seq, 0, 8);
    send_frame(1'b1);
    // dropped partial frame, then a full frame with frame start
    for (int i = 0; i < 40; i++) send_byte($urandom_range(255), i == 0);
    random_frame(next_seq(), 0, 8);
    send_frame(1'b1);
    // no frame start: position wraps to byte 0
    random_frame(next_seq(), 0, 8);
    send_frame(1'b0);
    // sequence reset handshake: the reset byte sent twice
    random_frame(SeqResetHost, 0, 8);
    send_frame(1'b1);
    random_frame(SeqResetHost, 0, 8);
    send_frame(1'b1);
  endtask

  // Receiver holds off while frames keep coming
  task automatic test_backpressure();
    write_reg(REG_MASK1, '1);
    write_reg(REG_MASK3, 64'hA5A5_5A5A_F0F0_0F0F);
    hold_req = 1'b1;
    for (int f = 0; f < 3; f++) begin
      random_frame(next_seq(), 10, 10);
      send_frame(1'b1);
    end
  endtask

  // Random frames, mostly well formed, with noise and register changes
  task automatic test_random_frames();
    int kind;
    quiet = 1'b1;
    for (int f = 0; f < 2; f++) begin
      random_frame(next_seq(), 10, 12);
      send_frame(1'b1);
    end
    quiet = 1'b0;
    for (int f = 0; f < 12; f++) begin
      if (f % 4 == 3) begin
        write_reg(REG_HEADER, 64'($urandom_range(255)));
        write_reg(reg_idx_e'($urandom_range(1, 4)), {$urandom, $urandom});
      end
      kind = $urandom_range(99);
      if (kind < 70) random_frame(next_seq(), 15, 12);
      else if (kind < 76) random_frame(SeqResetHost, 15, 12);
      else if (kind < 82) random_frame(8'($urandom_range(255)), 15, 12);
      else if (kind < 88) begin
        random_frame(next_seq(), 15, 12);
        frame_buf[0] = ~shadow_header;
      end else if (kind < 94) begin
        random_frame(next_seq(), 15, 12);
        frame_buf[FrameLen-1] ^= 8'($urandom_range(1, 255));
      end else begin
        for (int i = 0; i < $urandom_range(1, 100); i++)
          send_byte($urandom_range(255), i == 0);
        random_frame(next_seq(), 15, 12);
      end
      send_frame($urandom_range(9) != 0 || shadow_pos != 0);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    clk_i     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    quiet     = 1'b0;
    hold_left = 0;
    hold_req  = 1'b0;
    stall_cycles = 0;
    shadow_pos = 0;
    shadow_sum = '0;
    shadow_seq = '0;
    shadow_header = HeaderReset;
    foreach (shadow_mask[i]) shadow_mask[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_command_cases();
    test_frame_errors();
    test_backpressure();
    test_random_frames();

    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("[command_frame_validator_parser] OK");
    end else begin
      $display("[command_frame_validator_parser] ERROR");
    end
    $finish;
  end

endmodule
